// File: rtl/fqdc_pkg.sv
// ----------------------------------------------------------------------------
// fqdc_pkg
// Shared types and constants of the frame queue drop controller: operation
// and status codes, register indexes, drop patterns and the control bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fqdc_pkg;

	localparam logic [2:0] OP_FRAME = 3'd0;
	localparam logic [2:0] OP_END   = 3'd1;
	localparam logic [2:0] OP_SHOW  = 3'd2;
	localparam logic [2:0] OP_FLUSH = 3'd3;
	localparam logic [2:0] OP_DRAIN = 3'd4;

	localparam logic [3:0] ST_ADMITTED     = 4'd0;
	localparam logic [3:0] ST_DISCARDED    = 4'd1;
	localparam logic [3:0] ST_DROPPED      = 4'd2;
	localparam logic [3:0] ST_FULL         = 4'd3;
	localparam logic [3:0] ST_EMPTY        = 4'd4;
	localparam logic [3:0] ST_SHOWN        = 4'd5;
	localparam logic [3:0] ST_END_REACHED  = 4'd6;
	localparam logic [3:0] ST_FLUSHED      = 4'd7;
	localparam logic [3:0] ST_DRAIN_PEND   = 4'd8;
	localparam logic [3:0] ST_END_QUEUED   = 4'd9;
	localparam logic [3:0] ST_END_IGNORED  = 4'd10;

	localparam logic [1:0] CFG_DEPTH   = 2'd0;
	localparam logic [1:0] CFG_DROP_EN = 2'd1;
	localparam logic [1:0] CFG_DISCARD = 2'd2;

	localparam logic [3:0] DEPTH_RESET = 4'd8;
	localparam logic [4:0] FILL_SCALE  = 5'd21;
	localparam int         NUM_THRESH  = 7;
	localparam logic [2:0] MAX_LEVEL   = 3'd6;

	typedef logic [7:0] mask_t;

	// The last entry repeats the first so that an out-of-range level wraps.
	localparam mask_t DROP_MASK [8] = '{
		8'h00, 8'h01, 8'h11, 8'h49, 8'h55, 8'h77, 8'h7F, 8'h00
	};

	typedef struct packed {
		logic capture;
		logic commit;
	} fqdc_cmd_t;

	typedef struct packed {
		logic has_result;
	} fqdc_stat_t;

endpackage

`default_nettype wire

// File: rtl/frame_queue_drop_controller_unit.sv
// ----------------------------------------------------------------------------
// frame_queue_drop_controller_unit
// Admits video frame timestamps into a ring of slots, drops frames by a
// pattern chosen from the queue fill, and pops timestamps for display.
// ----------------------------------------------------------------------------
// Usage:
// An item (operation, pts) is taken on the input channel when in_valid and
// in_ready are high. in_ready is high whenever no item is in execution, also
// while a finished result still waits on the output channel.
// The item is captured and the timestamp RAM read is registered at the edge
// that accepts it; the block then executes it once the output register is
// free, and the result (status, slot, pts_out, drop_level) is registered
// and shown on out_valid. The block takes no new item until it has
// committed the current one. Operation codes 5 to 7 give no result.
// When the receiver stalls, the result is held and the next item waits in
// execution until the output register frees.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
// the user makes them only while the block is idle; no logic enforces it.
// Reset clears pointers, counters and the drop state; the timestamp store
// holds no defined contents until written.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_queue_drop_controller_unit import fqdc_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] pts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [3:0]  status,
	output logic      [2:0]  slot,
	output logic      [63:0] pts_out,
	output logic      [2:0]  drop_level
);

	fqdc_cmd_t  cmd;
	fqdc_stat_t stat;

	fqdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	fqdc_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operation (operation),
		.pts       (pts),
		.status    (status),
		.slot      (slot),
		.pts_out   (pts_out),
		.drop_level(drop_level)
	);

endmodule

`default_nettype wire

// File: rtl/fqdc_ram.sv
// ----------------------------------------------------------------------------
// fqdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fqdc_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fqdc_ctrl.sv
// ----------------------------------------------------------------------------
// fqdc_ctrl
// Controller: takes one item, lets the datapath execute it once the output
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fqdc_ctrl import fqdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output fqdc_cmd_t       cmd,
	input  wire fqdc_stat_t stat
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= stat.has_result;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/fqdc_dp.sv
// ----------------------------------------------------------------------------
// fqdc_dp
// Datapath: configuration registers, ring pointers and counters, the drop
// pattern logic, the timestamp RAM and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fqdc_dp import fqdc_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire fqdc_cmd_t   cmd,
	output fqdc_stat_t       stat,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] pts,
	output logic      [3:0]  status,
	output logic      [2:0]  slot,
	output logic      [63:0] pts_out,
	output logic      [2:0]  drop_level
);

	localparam int SW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = (SW > 4 ? SW : 4) + 1;
	localparam int DCAP = (QUEUE_DEPTH < 15) ? QUEUE_DEPTH : 15;

	logic [3:0]    depth_cfg_q;
	logic          drop_en_q;
	logic [SW-1:0] ws_q, rs_q;
	logic [3:0]    fill_q;
	logic [7:0]    adm_q;
	logic [7:0]    discard_q;
	logic [2:0]    phase_q;
	logic [2:0]    level_q;
	logic [2:0]    op_q;
	logic [63:0]   pts_q;
	logic [3:0]    status_q;
	logic [2:0]    slot_q;
	logic [63:0]   pts_out_q;

	logic [3:0]    depth_eff;
	logic [CW-1:0] depth_c, ws_inc, rs_inc;
	logic [SW-1:0] ws_next, rs_next;
	logic          full;
	logic          keep;
	logic [64:0]   rdata;

	logic [SW-1:0] n_ws, n_rs;
	logic [3:0]    n_fill;
	logic [7:0]    n_adm, n_discard;
	logic [2:0]    n_phase, n_level;
	logic          wr_en;
	logic [64:0]   wr_data;
	logic [3:0]    res_status;
	logic [CW-1:0] res_slot;
	logic [63:0]   res_pts;
	logic          has_result;

	logic [8:0]    fill_scaled;
	logic [2:0]    thresh_cnt;
	logic [2:0]    new_level;

	always_comb begin
		if (depth_cfg_q == 4'd0) begin
			depth_eff = 4'd1;
		end else if (depth_cfg_q > 4'(DCAP)) begin
			depth_eff = 4'(DCAP);
		end else begin
			depth_eff = depth_cfg_q;
		end
	end

	assign depth_c = CW'(depth_eff);
	assign ws_inc  = CW'(ws_q) + CW'(1);
	assign rs_inc  = CW'(rs_q) + CW'(1);
	assign ws_next = (ws_inc >= depth_c) ? '0 : ws_inc[SW-1:0];
	assign rs_next = (rs_inc >= depth_c) ? '0 : rs_inc[SW-1:0];
	assign full    = (fill_q >= depth_eff);
	assign keep    = !DROP_MASK[level_q][phase_q];

	// The level counts the thresholds k = 1..7 with 21*fill < k*depth, capped at MAX_LEVEL.
	always_comb begin
		logic [2:0] cnt;
		cnt = '0;
		fill_scaled = 9'(n_fill) * 9'(FILL_SCALE);
		for (int k = 1; k <= NUM_THRESH; k++) begin
			if (fill_scaled < 9'(k) * 9'(depth_eff)) begin
				cnt = cnt + 3'd1;
			end
		end
		thresh_cnt = cnt;
		new_level  = (thresh_cnt > MAX_LEVEL) ? MAX_LEVEL : thresh_cnt;
	end

	always_comb begin
		n_ws       = ws_q;
		n_rs       = rs_q;
		n_fill     = fill_q;
		n_adm      = adm_q;
		n_discard  = discard_q;
		n_phase    = phase_q;
		n_level    = level_q;
		wr_en      = 1'b0;
		wr_data    = {1'b0, pts_q};
		res_status = ST_ADMITTED;
		res_slot   = '0;
		res_pts    = '0;
		has_result = 1'b1;
		unique case (op_q)
			OP_FRAME: begin
				if (discard_q != 8'd0) begin
					n_discard  = discard_q - 8'd1;
					res_status = ST_DISCARDED;
				end else if (keep && full) begin
					res_status = ST_FULL;
				end else begin
					if (keep) begin
						if (adm_q != 8'hFF) begin
							n_adm = adm_q + 8'd1;
						end
						wr_en      = 1'b1;
						wr_data    = {1'b0, pts_q};
						res_slot   = CW'(ws_q);
						n_ws       = ws_next;
						n_fill     = fill_q + 4'd1;
						res_status = ST_ADMITTED;
					end else begin
						res_status = ST_DROPPED;
					end
					if (drop_en_q && (n_adm > 8'(depth_eff))) begin
						n_phase = phase_q + 3'd1;
						n_level = new_level;
					end
				end
			end
			OP_END: begin
				if (adm_q == 8'd0) begin
					res_status = ST_END_IGNORED;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					wr_en      = 1'b1;
					wr_data    = {1'b1, 64'd0};
					res_slot   = CW'(ws_q);
					n_ws       = ws_next;
					n_fill     = fill_q + 4'd1;
					res_status = ST_END_QUEUED;
				end
			end
			OP_SHOW: begin
				if (fill_q == 4'd0) begin
					res_status = ST_EMPTY;
				end else if (rdata[64]) begin
					res_slot   = CW'(rs_q);
					n_ws       = '0;
					n_rs       = '0;
					n_fill     = '0;
					res_status = ST_END_REACHED;
				end else begin
					res_slot   = CW'(rs_q);
					res_pts    = rdata[63:0];
					n_rs       = rs_next;
					n_fill     = fill_q - 4'd1;
					res_status = ST_SHOWN;
				end
			end
			OP_FLUSH: begin
				n_ws       = '0;
				n_rs       = '0;
				n_fill     = '0;
				n_adm      = '0;
				res_status = ST_FLUSHED;
			end
			OP_DRAIN: begin
				if (fill_q == 4'd0) begin
					n_adm      = '0;
					res_status = ST_FLUSHED;
				end else begin
					res_status = ST_DRAIN_PEND;
				end
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	assign stat.has_result = has_result;

	fqdc_ram #(
		.WIDTH(65),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.commit && wr_en),
		.waddr(ws_q),
		.wdata(wr_data),
		.raddr(rs_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cfg_q <= DEPTH_RESET;
			drop_en_q   <= 1'b0;
			ws_q        <= '0;
			rs_q        <= '0;
			fill_q      <= '0;
			adm_q       <= '0;
			discard_q   <= '0;
			phase_q     <= '0;
			level_q     <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_DEPTH:   depth_cfg_q <= cfg_data[3:0];
					CFG_DROP_EN: drop_en_q   <= cfg_data[0];
					CFG_DISCARD: discard_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				ws_q      <= n_ws;
				rs_q      <= n_rs;
				fill_q    <= n_fill;
				adm_q     <= n_adm;
				discard_q <= n_discard;
				phase_q   <= n_phase;
				level_q   <= n_level;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			pts_q <= pts;
		end
		if (cmd.commit && has_result) begin
			status_q  <= res_status;
			slot_q    <= res_slot[2:0];
			pts_out_q <= res_pts;
		end
	end

	assign status     = status_q;
	assign slot       = slot_q;
	assign pts_out    = pts_out_q;
	assign drop_level = level_q;

endmodule

`default_nettype wire

// File: rtl/fqdc_checker.sv
// ----------------------------------------------------------------------------
// fqdc_checker
// Port-level checks of the frame queue drop controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fqdc_checker import fqdc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  status,
	input wire logic [63:0] pts_out,
	input wire logic [2:0]  drop_level
);

	// An accepted item occupies the block: in_ready drops once it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while the previous one executes");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pts_out))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_END_IGNORED && drop_level <= MAX_LEVEL)
		else $error("result code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_SHOWN |-> pts_out == 64'd0)
		else $error("timestamp reported without a shown frame");

endmodule

bind frame_queue_drop_controller_unit fqdc_checker u_fqdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.pts_out   (pts_out),
	.drop_level(drop_level)
);

`default_nettype wire

// File: bench/frame_queue_checker.sv
// ----------------------------------------------------------------------------
// frame_queue_checker
// Watches the configuration port and both item channels of the frame queue
// drop controller. It keeps its own copy of the slot ring, the counters and
// the drop state, works out the result of every accepted item and compares
// each result item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module frame_queue_checker import fqdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [63:0] pts,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  status,
	input  logic [2:0]  slot,
	input  logic [63:0] pts_out,
	input  logic [2:0]  drop_level,
	output int          mismatch_total,
	output int          results_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_SLOTS = 8;
	localparam logic [7:0] DROP_PATTERN [7] = '{
		8'h00, 8'h01, 8'h11, 8'h49, 8'h55, 8'h77, 8'h7F
	};

	typedef struct packed {
		logic [3:0]  status;
		logic [2:0]  slot;
		logic [63:0] pts_out;
		logic [2:0]  level;
	} frame_result_t;

	logic [3:0]    depth_setting;
	logic          drop_on;
	logic [63:0]   stamp_copy [RING_SLOTS];
	logic          end_mark_copy [RING_SLOTS];
	logic [2:0]    wr_slot;
	logic [2:0]    rd_slot;
	logic [3:0]    fill;
	logic [7:0]    admits;
	logic [7:0]    discards_left;
	logic [2:0]    phase;
	logic [2:0]    level;
	frame_result_t expected_results [$];
	frame_result_t oldest;
	int            errors;

	function automatic int active_depth();
		if (depth_setting == 4'd0)
			return 1;
		if (int'(depth_setting) > RING_SLOTS)
			return RING_SLOTS;
		return int'(depth_setting);
	endfunction

	function automatic logic [2:0] advance(input logic [2:0] s, input int depth);
		return (int'(s) + 1 >= depth) ? 3'd0 : s + 3'd1;
	endfunction

	// The level counts the thresholds k = 7 down to 1 with 21*fill < k*depth, capped at MAX_LEVEL.
	function automatic logic [2:0] level_from_fill(input int depth);
		int k;
		k = 0;
		while (k < 7 && 21 * int'(fill) < (7 - k) * depth)
			k++;
		return (k > 6) ? MAX_LEVEL : 3'(k);
	endfunction

	task automatic empty_ring();
		wr_slot = 3'd0;
		rd_slot = 3'd0;
		fill = 4'd0;
	endtask

	task automatic predict_item(input logic [2:0] op, input logic [63:0] ts);
		frame_result_t r;
		int depth;
		logic keep;
		logic gives_result;
		depth = active_depth();
		r = '0;
		gives_result = 1'b1;
		keep = !DROP_PATTERN[level][phase];
		case (op)
		OP_FRAME: begin
			if (discards_left != 8'd0) begin
				discards_left = discards_left - 8'd1;
				r.status = ST_DISCARDED;
			end else if (keep && int'(fill) >= depth) begin
				r.status = ST_FULL;
			end else begin
				if (keep) begin
					if (admits != 8'hFF)
						admits = admits + 8'd1;
					stamp_copy[wr_slot] = ts;
					end_mark_copy[wr_slot] = 1'b0;
					r.slot = wr_slot;
					wr_slot = advance(wr_slot, depth);
					fill = fill + 4'd1;
					r.status = ST_ADMITTED;
				end else begin
					r.status = ST_DROPPED;
				end
				if (drop_on && int'(admits) > depth) begin
					phase = phase + 3'd1;
					level = level_from_fill(depth);
				end
			end
		end
		OP_END: begin
			if (admits == 8'd0) begin
				r.status = ST_END_IGNORED;
			end else if (int'(fill) >= depth) begin
				r.status = ST_FULL;
			end else begin
				stamp_copy[wr_slot] = 64'd0;
				end_mark_copy[wr_slot] = 1'b1;
				r.slot = wr_slot;
				wr_slot = advance(wr_slot, depth);
				fill = fill + 4'd1;
				r.status = ST_END_QUEUED;
			end
		end
		OP_SHOW: begin
			if (fill == 4'd0) begin
				r.status = ST_EMPTY;
			end else if (end_mark_copy[rd_slot]) begin
				r.slot = rd_slot;
				empty_ring();
				r.status = ST_END_REACHED;
			end else begin
				r.slot = rd_slot;
				r.pts_out = stamp_copy[rd_slot];
				rd_slot = advance(rd_slot, depth);
				fill = fill - 4'd1;
				r.status = ST_SHOWN;
			end
		end
		OP_FLUSH: begin
			empty_ring();
			admits = 8'd0;
			r.status = ST_FLUSHED;
		end
		OP_DRAIN: begin
			if (fill == 4'd0) begin
				admits = 8'd0;
				r.status = ST_FLUSHED;
			end else begin
				r.status = ST_DRAIN_PEND;
			end
		end
		default: gives_result = 1'b0;
		endcase
		r.level = level;
		if (gives_result)
			expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_setting = DEPTH_RESET;
			drop_on = 1'b0;
			for (int i = 0; i < RING_SLOTS; i++) begin
				stamp_copy[i] = 64'd0;
				end_mark_copy[i] = 1'b0;
			end
			empty_ring();
			admits = 8'd0;
			discards_left = 8'd0;
			phase = 3'd0;
			level = 3'd0;
			expected_results.delete();
			errors = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
				CFG_DEPTH:   depth_setting = cfg_data[3:0];
				CFG_DROP_EN: drop_on = cfg_data[0];
				CFG_DISCARD: discards_left = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_item(operation, pts);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with nothing expected: status %0d slot %0d", status, slot);
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					if (status !== oldest.status) begin
						$error("status: expected %0d, actual %0d", oldest.status, status);
						errors++;
					end
					if (slot !== oldest.slot) begin
						$error("slot: expected %0d, actual %0d", oldest.slot, slot);
						errors++;
					end
					if (pts_out !== oldest.pts_out) begin
						$error("pts_out: expected %h, actual %h", oldest.pts_out, pts_out);
						errors++;
					end
					if (drop_level !== oldest.level) begin
						$error("drop_level: expected %0d, actual %0d", oldest.level,
							drop_level);
						errors++;
					end
				end
			end
		end
		mismatch_total <= errors;
		results_waiting <= expected_results.size();
	end

endmodule

// File: bench/tb_frame_queue_drop_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_frame_queue_drop_controller_unit
// Drives the frame queue drop controller with a directed opening and then
// random phases of frame, display, end, flush and drain items under several
// queue depths, drop settings and startup discard counts. The sender works in
// bursts and the receiver stalls on its own pattern; a side checker predicts
// every result item and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_frame_queue_drop_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import fqdc_pkg::*;

	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 110;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  operation;
	logic [63:0] pts;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  status;
	logic [2:0]  slot;
	logic [63:0] pts_out;
	logic [2:0]  drop_level;
	int          mismatch_total;
	int          results_waiting;
	bit          hold_off_req;

	frame_queue_drop_controller_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.pts        (pts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.pts_out    (pts_out),
		.drop_level (drop_level)
	);

	frame_queue_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.pts             (pts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot            (slot),
		.pts_out         (pts_out),
		.drop_level      (drop_level),
		.mismatch_total  (mismatch_total),
		.results_waiting (results_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int mode;
		int span;
		out_ready = 1'b0;
		mode = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (64) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(10, 80);
				end
				span--;
				case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
				endcase
			end
		end
	end

	task automatic offer(input logic [2:0] op, input logic [63:0] ts);
		in_valid <= 1'b1;
		operation <= op;
		pts <= ts;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [3:0] depth, input logic drop,
			input logic [7:0] discard);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DEPTH;
		cfg_data <= {4'd0, depth};
		@(posedge clk);
		cfg_index <= CFG_DROP_EN;
		cfg_data <= {7'd0, drop};
		@(posedge clk);
		cfg_index <= CFG_DISCARD;
		cfg_data <= discard;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [2:0] pick_operation(input int show_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return OP_DRAIN + 3'($urandom_range(1, 3));
		if (r < 6 + show_pct)
			return OP_SHOW;
		if (r < 11 + show_pct)
			return OP_END;
		if (r < 14 + show_pct)
			return OP_FLUSH;
		if (r < 19 + show_pct)
			return OP_DRAIN;
		return OP_FRAME;
	endfunction

	initial begin
		logic [63:0] corner_stamps [4];
		logic [3:0]  depth_plan [PHASES];
		logic        drop_plan [PHASES];
		logic [7:0]  discard_plan [PHASES];
		logic [2:0]  op;
		logic [63:0] ts;
		int          show_pct;
		int          count;
		int          burst;

		corner_stamps = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA};
		depth_plan = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2, 4'd8};
		drop_plan = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
		discard_plan = '{8'd0, 8'd2, 8'd0, 8'd4, 8'd0, 8'd1, 8'd3, 8'd0};

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_DEPTH;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		operation = OP_FRAME;
		pts = 64'd0;
		hold_off_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue cases and codes outside the operation set.
		offer(OP_SHOW, 64'd0);
		offer(OP_DRAIN, 64'd0);
		offer(OP_END, 64'd0);
		for (int k = 1; k <= 3; k++)
			offer(OP_DRAIN + 3'(k), 64'hFFFF_FFFF_FFFF_FFFF);

		// Fill every slot once so that no later read meets an unwritten entry.
		for (int i = 0; i < 8; i++)
			offer(OP_FRAME, (i < 4) ? corner_stamps[i] : {$urandom, $urandom});
		offer(OP_FRAME, {$urandom, $urandom});
		offer(OP_END, 64'd0);
		offer(OP_DRAIN, 64'd0);
		offer(OP_SHOW, 64'd0);
		offer(OP_SHOW, 64'd0);
		offer(OP_END, 64'd0);
		offer(OP_FLUSH, 64'd0);

		settle();
		apply_settings(4'd8, 1'b0, 8'd255);
		offer(OP_FRAME, {$urandom, $urandom});
		offer(OP_FRAME, {$urandom, $urandom});
		settle();
		apply_settings(4'd8, 1'b0, 8'd0);
		offer(OP_END, 64'd0);
		offer(OP_FRAME, {$urandom, $urandom});
		offer(OP_END, 64'd0);
		offer(OP_SHOW, 64'd0);
		offer(OP_SHOW, 64'd0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			apply_settings(depth_plan[p], drop_plan[p], discard_plan[p]);
			if (p == 2)
				hold_off_req = 1'b1;
			show_pct = $urandom_range(20, 50);
			count = 0;
			while (count < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					op = pick_operation(show_pct);
					ts = ($urandom_range(0, 19) == 0) ? corner_stamps[$urandom_range(0, 3)]
						: {$urandom, $urandom};
					offer(op, ts);
					if (op <= OP_DRAIN)
						count++;
				end
				if ($urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
		end

		settle();
		if (mismatch_total == 0 && results_waiting == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
